[sv/fsamb_pkg.sv]
package fsamb_pkg;

  localparam int HILBERT_TAPS = 64;
  localparam int TAP_W        = $clog2(HILBERT_TAPS);
  localparam int REAL_TAP     = HILBERT_TAPS / 2;

  localparam longint Q30_ONE  = 64'sd1073741824;

  // configuration register indexes
  localparam logic [2:0] REG_STEP_TARGET = 3'd0;
  localparam logic [2:0] REG_SMOOTH      = 3'd1;
  localparam logic [2:0] REG_ENGINE      = 3'd2;
  localparam logic [2:0] REG_STEREO      = 3'd3;
  localparam logic [2:0] REG_SHAPE       = 3'd4;
  localparam logic [2:0] REG_AM_INVERT   = 3'd5;
  localparam logic [2:0] REG_MIX         = 3'd6;
  localparam logic [2:0] REG_BYPASS_THR  = 3'd7;

  typedef logic signed [23:0] sample_t;
  typedef logic signed [31:0] coef_t;
  typedef coef_t coef_tab_t [HILBERT_TAPS];
  typedef logic signed [31:0] horner_tab_t [4];

  // quarter-wave polynomial, Horner order after the leading term
  localparam logic signed [31:0] SIN_LEAD = 32'sd172272;
  localparam horner_tab_t SIN_HORNER = '{
    -32'sd5026995, 32'sd85569306, -32'sd693598669, 32'sd1686629713
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIR,
    ST_POST,
    ST_DONE
  } state_t;

  function automatic longint sinq_f(logic [31:0] p);
    logic [1:0] q;
    longint f, t, t2, a, r;
    q  = p[31:30];
    f  = longint'({34'd0, p[29:0]});
    t  = q[0] ? (Q30_ONE - f) : f;
    t2 = (t * t) >>> 30;
    a  = longint'(SIN_LEAD);
    for (int i = 0; i < 4; i++) begin
      a = longint'(SIN_HORNER[i]) + ((a * t2) >>> 30);
    end
    r = (a * t) >>> 30;
    if (r > Q30_ONE) r = Q30_ONE;
    if (r < 0) r = 0;
    return q[1] ? -r : r;
  endfunction

  // shift-and-subtract quotient, only used while building constant tables
  function automatic longint unsigned udiv_f(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Blackman-windowed Hilbert taps, Q30
  function automatic coef_tab_t build_coefs();
    coef_tab_t tab;
    longint n, g, c1, c2, w;
    longint unsigned phl, gmag;
    logic [31:0] ph;
    for (int i = 0; i < HILBERT_TAPS; i++) begin
      n = longint'(i) - longint'(REAL_TAP);
      // quotient truncates toward zero
      if (n[0]) begin
        gmag = udiv_f(64'd683565276, longint'((n < 0) ? -n : n));
        g    = (n < 0) ? -longint'(gmag) : longint'(gmag);
      end else begin
        g = 64'sd0;
      end
      phl = udiv_f(longint'(i) << 32, longint'(HILBERT_TAPS - 1));
      ph  = phl[31:0];
      c1  = sinq_f(ph + 32'h4000_0000);
      c2  = sinq_f((ph << 1) + 32'h4000_0000);
      w   = 64'sd450971566 - (c1 >>> 1) + ((c2 * 64'sd85899346) >>> 30);
      tab[i] = coef_t'((g * w) >>> 30);
    end
    return tab;
  endfunction

  localparam coef_tab_t COEF = build_coefs();

endpackage

[sv/frequency_shifter_am_blend.sv]
// Stereo frequency shifter blended with amplitude modulation. One beat on the
// input (a left/right pair, Q1.23) gives one beat on the output. For each item
// the history chain rotates once round its HILBERT_TAPS cells past a single
// multiply-accumulate per channel, then eight arithmetic steps and the output
// load follow. The sine and cosine units run alongside the rotation. A new input
// beat is taken only when the block is idle, but a finished result may still be
// waiting in the output register while the next item is taken. Config should
// only be written while idle. The history, phase and step smoother reset to zero
// with rst_n.
module frequency_shifter_am_blend (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsamb_pkg::sample_t in_left_sample,
  input  fsamb_pkg::sample_t in_right_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output fsamb_pkg::sample_t out_left_out,
  output fsamb_pkg::sample_t out_right_out,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import fsamb_pkg::*;

  // config
  logic signed [31:0] target_r;
  logic [15:0]        smooth_r;
  logic [16:0]        engine_r;
  logic               stereo_r;
  logic [16:0]        shape_r;
  logic               inv_r;
  logic [16:0]        mix_r;
  logic [30:0]        thr_r;

  // control
  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] cnt_r, cnt_nxt;
  logic             in_acc, rot_en, out_load;
  logic             out_valid_r;

  // state
  logic signed [47:0] s_r;
  logic [31:0]        phase_r;

  // history chain
  sample_t cell_l [HILBERT_TAPS];
  sample_t cell_r [HILBERT_TAPS];
  sample_t d0_l, d0_r;

  // datapath
  logic signed [48:0] diff_r;
  logic signed [50:0] hik_r;
  logic [32:0]        lok_r;
  logic signed [63:0] acc_l_r, acc_r_r;
  sample_t            real_l_r, real_r_r;
  logic signed [27:0] hl_r, hr_r;
  logic signed [33:0] wave_a_r, wave_d_r;
  logic signed [17:0] frac_r;
  logic               bypass_r;
  logic signed [50:0] wmul_r;
  logic signed [55:0] lc_r, rc_r;
  logic signed [59:0] ls_r, rs_r;
  logic signed [31:0] wave_r;
  logic signed [31:0] fs_l_r, fs_r_r;
  logic signed [55:0] aml_p_r, amr_p_r;
  logic signed [31:0] am_l_r, am_r_r;
  logic signed [50:0] bl_l_r, bl_r_r;
  logic signed [33:0] wet_l_r, wet_r_r;
  logic signed [52:0] mx_l_r, mx_r_r;
  sample_t            out_l_r, out_r_r;

  logic signed [31:0] sin_w, cos_w;
  logic [16:0]        k_w, eng_w, mix_w, shape_w;
  logic signed [31:0] step_w;
  logic [32:0]        mag_w;
  logic [17:0]        scaled_w;
  logic [1:0]         seg_w;
  logic signed [33:0] tri_w, sqr_w, saw_w;
  logic [TAP_W-1:0]   cidx_w;
  logic signed [61:0] fsd_l_w, fsd_r_w;
  logic signed [31:0] am_rs_w, fs_rs_w;
  logic signed [37:0] sum_l_w, sum_r_w;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      smooth_r <= 16'd65263;
      engine_r <= 17'd65536;
      stereo_r <= 1'b1;
      shape_r  <= '0;
      inv_r    <= 1'b0;
      mix_r    <= 17'd65536;
      thr_r    <= 31'd90;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_STEP_TARGET: target_r <= cfg_data;
        REG_SMOOTH:      smooth_r <= cfg_data[15:0];
        REG_ENGINE:      engine_r <= cfg_data[16:0];
        REG_STEREO:      stereo_r <= cfg_data[0];
        REG_SHAPE:       shape_r  <= cfg_data[16:0];
        REG_AM_INVERT:   inv_r    <= cfg_data[0];
        REG_MIX:         mix_r    <= cfg_data[16:0];
        REG_BYPASS_THR:  thr_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // blends above unity act as unity
  assign eng_w   = engine_r[16] ? 17'd65536 : engine_r;
  assign mix_w   = mix_r[16]    ? 17'd65536 : mix_r;
  assign shape_w = shape_r[16]  ? 17'd65536 : shape_r;
  assign k_w     = 17'd65536 - {1'b0, smooth_r};

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FIR;
          cnt_nxt   = '0;
        end
      end
      ST_FIR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == TAP_W'(HILBERT_TAPS - 1)) begin
          state_nxt = ST_POST;
          cnt_nxt   = '0;
        end
      end
      ST_POST: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == TAP_W'(7)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rot_en   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_FIR:  rot_en   = 1'b1;
      ST_POST: ;
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- history chain
  // newest sample shifts in at cell 0; a full rotation walks every tap past
  // the last cell and leaves the chain as it was
  assign d0_l = in_acc ? in_left_sample  : cell_l[HILBERT_TAPS-1];
  assign d0_r = in_acc ? in_right_sample : cell_r[HILBERT_TAPS-1];

  for (genvar g = 0; g < HILBERT_TAPS; g++) begin : g_cell
    fsamb_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (in_acc || rot_en),
      .d_l   ((g == 0) ? d0_l : cell_l[(g == 0) ? 0 : g - 1]),
      .d_r   ((g == 0) ? d0_r : cell_r[(g == 0) ? 0 : g - 1]),
      .q_l   (cell_l[g]),
      .q_r   (cell_r[g])
    );
  end

  // the last cell holds tap (TAPS-1-cnt) during rotation step cnt
  assign cidx_w = TAP_W'(HILBERT_TAPS - 1) - cnt_r;

  // ---------------------------------------------------------------- oscillator
  fsamb_sinq u_sin (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .phase  (phase_r),
    .result (sin_w)
  );

  fsamb_sinq u_cos (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .phase  (phase_r + 32'h4000_0000),
    .result (cos_w)
  );

  assign step_w = s_r[47:16];
  assign mag_w  = step_w[31] ? 33'(-{step_w[31], step_w}) : {1'b0, step_w};

  // smoother and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r     <= '0;
      phase_r <= '0;
    end else begin
      if (state_r == ST_FIR && cnt_r == TAP_W'(1))
        s_r <= 48'(s_r + hik_r + $signed({1'b0, lok_r[32:16]}));
      if (out_load)
        phase_r <= phase_r + step_w;
    end
  end

  // ---------------------------------------------------------------- wave morph
  assign scaled_w = 18'(shape_w) * 18'd3;
  assign seg_w    = (scaled_w[17:16] == 2'd3) ? 2'd2 : scaled_w[17:16];
  assign tri_w    = ($signed({2'b0, phase_r}) - 34'sh8000_0000 < 0)
                    ? (34'sh8000_0000 - $signed({2'b0, phase_r}) - 34'sh4000_0000)
                    : ($signed({2'b0, phase_r}) - 34'sh8000_0000 - 34'sh4000_0000);
  assign sqr_w    = phase_r[31] ? -34'sh4000_0000 : 34'sh4000_0000;
  assign saw_w    = $signed({3'b0, phase_r[31:1]}) - 34'sh4000_0000;

  // ---------------------------------------------------------------- datapath
  assign fsd_l_w = 62'(lc_r) - 62'(ls_r);
  assign fsd_r_w = 62'(rc_r) - 62'(rs_r);
  assign am_rs_w = stereo_r ? am_r_r : am_l_r;
  assign fs_rs_w = stereo_r ? fs_r_r : fs_l_r;
  assign sum_l_w = 38'(real_l_r) + 38'(mx_l_r >>> 16);
  assign sum_r_w = 38'(real_r_r) + 38'(mx_r_r >>> 16);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r  <= 49'($signed({target_r, 16'h0})) - 49'(s_r);
      acc_l_r <= '0;
      acc_r_r <= '0;
    end

    if (state_r == ST_FIR) begin
      acc_l_r <= acc_l_r + (64'(cell_l[HILBERT_TAPS-1]) * 64'(COEF[cidx_w]));
      acc_r_r <= acc_r_r + (64'(cell_r[HILBERT_TAPS-1]) * 64'(COEF[cidx_w]));
      if (cnt_r == '0) begin
        real_l_r <= cell_l[REAL_TAP];
        real_r_r <= cell_r[REAL_TAP];
        hik_r    <= $signed(diff_r[48:16]) * $signed({1'b0, k_w});
        lok_r    <= diff_r[15:0] * k_w;
      end
    end

    if (state_r == ST_POST) begin
      case (cnt_r[2:0])
        3'd0: begin
          hl_r     <= 28'(acc_l_r >>> 30);
          hr_r     <= 28'(acc_r_r >>> 30);
          bypass_r <= mag_w < {2'b0, thr_r};
          frac_r   <= $signed({1'b0, 17'(scaled_w - {seg_w, 16'h0})});
          case (seg_w)
            2'd0: begin
              wave_a_r <= 34'(sin_w);
              wave_d_r <= tri_w - 34'(sin_w);
            end
            2'd1: begin
              wave_a_r <= tri_w;
              wave_d_r <= sqr_w - tri_w;
            end
            default: begin
              wave_a_r <= sqr_w;
              wave_d_r <= saw_w - sqr_w;
            end
          endcase
        end
        3'd1: begin
          wmul_r <= wave_d_r * frac_r;
          lc_r   <= real_l_r * cos_w;
          rc_r   <= real_r_r * cos_w;
          ls_r   <= hl_r * sin_w;
          rs_r   <= hr_r * sin_w;
        end
        3'd2: begin
          wave_r <= inv_r ? -32'(wave_a_r + 34'(wmul_r >>> 16))
                          :  32'(wave_a_r + 34'(wmul_r >>> 16));
          fs_l_r <= 32'(fsd_l_w >>> 30);
          fs_r_r <= 32'(fsd_r_w >>> 30);
        end
        3'd3: begin
          aml_p_r <= real_l_r * wave_r;
          amr_p_r <= real_r_r * wave_r;
        end
        3'd4: begin
          am_l_r <= 32'(aml_p_r >>> 30);
          am_r_r <= 32'(amr_p_r >>> 30);
        end
        3'd5: begin
          // mono style: right wet follows the left result
          bl_l_r <= (33'(fs_l_r) - 33'(am_l_r)) * $signed({1'b0, eng_w});
          bl_r_r <= (33'(fs_rs_w) - 33'(am_rs_w)) * $signed({1'b0, eng_w});
        end
        3'd6: begin
          if (bypass_r) begin
            wet_l_r <= 34'(real_l_r);
            wet_r_r <= stereo_r ? 34'(real_r_r) : 34'(real_l_r);
          end else begin
            wet_l_r <= 34'(am_l_r) + 34'(bl_l_r >>> 16);
            wet_r_r <= 34'(am_rs_w) + 34'(bl_r_r >>> 16);
          end
        end
        3'd7: begin
          mx_l_r <= (35'(wet_l_r) - 35'(real_l_r)) * $signed({1'b0, mix_w});
          mx_r_r <= (35'(wet_r_r) - 35'(real_r_r)) * $signed({1'b0, mix_w});
        end
        default: ;
      endcase
    end

    if (out_load) begin
      out_l_r <= (sum_l_w > 38'sd8388607) ? 24'sd8388607 :
                 (sum_l_w < -38'sd8388608) ? -24'sd8388608 : 24'(sum_l_w);
      out_r_r <= (sum_r_w > 38'sd8388607) ? 24'sd8388607 :
                 (sum_r_w < -38'sd8388608) ? -24'sd8388608 : 24'(sum_r_w);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;

endmodule

[sv/fsamb_cell.sv]
module fsamb_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  fsamb_pkg::sample_t d_l,
  input  fsamb_pkg::sample_t d_r,
  output fsamb_pkg::sample_t q_l,
  output fsamb_pkg::sample_t q_r
);
  import fsamb_pkg::*;

  sample_t l_r, r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_r <= '0;
      r_r <= '0;
    end else if (en) begin
      l_r <= d_l;
      r_r <= d_r;
    end
  end

  assign q_l = l_r;
  assign q_r = r_r;

endmodule

[sv/fsamb_sinq.sv]
module fsamb_sinq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic signed [31:0] result
);
  import fsamb_pkg::*;

  logic [2:0]         cnt_r;
  logic               run_r;
  logic [30:0]        t_r;
  logic [30:0]        t2_r;
  logic               neg_r;
  logic signed [31:0] a_r;
  logic signed [31:0] res_r;
  logic [30:0]        t_w;
  logic [61:0]        tt_w;
  logic signed [63:0] at2_w;
  logic signed [63:0] at_w;
  logic signed [33:0] r_w;

  assign t_w   = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
  assign tt_w  = t_r * t_r;
  assign at2_w = a_r * $signed({1'b0, t2_r});
  assign at_w  = a_r * $signed({1'b0, t_r});
  assign r_w   = at_w[63:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == 3'd5) run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r   <= t_w;
      neg_r <= phase[31];
      a_r   <= SIN_LEAD;
    end else if (run_r) begin
      case (cnt_r)
        3'd0: t2_r <= tt_w[60:30];
        3'd1, 3'd2, 3'd3, 3'd4: a_r <= SIN_HORNER[cnt_r[1:0] - 2'd1] + 32'(at2_w >>> 30);
        3'd5: begin
          if (r_w > 34'sd1073741824)
            res_r <= neg_r ? -32'sd1073741824 : 32'sd1073741824;
          else if (r_w < 34'sd0)
            res_r <= '0;
          else
            res_r <= neg_r ? -32'(r_w) : 32'(r_w);
        end
        default: ;
      endcase
    end
  end

  assign result = res_r;

endmodule
